// File: sv/mlb_pkg.sv
package mlb_pkg;

  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int PORT_W = 3;
  localparam int MASK_W = 8;
  localparam int ACT_W  = 4;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [TIME_W-1:0] AGE_RESET   = TIME_W'(300);
  localparam logic [ACT_W-1:0]  PORTS_RESET = ACT_W'(8);

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_AGE     = 2'd1,
    REG_OWN_MAC = 2'd2,
    REG_PORTS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_HOST      = 2'd0,
    KIND_BROADCAST = 2'd1,
    KIND_MULTICAST = 2'd2,
    KIND_OTHER     = 2'd3
  } pkt_kind_t;

  // broadcast to every cell of the table
  typedef struct packed {
    logic              cmp;
    logic              learn_wr;
    logic              drop;
    logic              any_match;
    logic [MAC_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [PORT_W-1:0] wr_port;
    logic [TIME_W-1:0] wr_expiry;
  } cell_ctrl_t;

  // accumulated from cell to cell along the chain
  typedef struct packed {
    logic              match;
    logic              live;
    logic [PORT_W-1:0] port;
  } cell_resp_t;

  function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
    return MASK_W'(1) << p;
  endfunction

endpackage

// File: sv/mlb_cell.sv
module mlb_cell
  import mlb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_resp_t resp_in,
  input  logic       free_in,
  output cell_resp_t resp_out,
  output logic       free_out
);

  logic              valid;
  logic [MAC_W-1:0]  mac;
  logic [PORT_W-1:0] port;
  logic [TIME_W-1:0] expiry;
  logic              match_q;
  logic              live_q;
  logic              wr;
  logic              hit_here;

  // refresh a matching entry, or claim this one if it is the lowest free cell
  assign wr = ctrl.learn_wr & (match_q | (~ctrl.any_match & ~valid & ~free_in));
  assign hit_here = match_q & live_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match_q <= valid && (mac == ctrl.key);
      end
      if (wr) begin
        valid <= 1'b1;
      end else if (ctrl.drop && match_q && !live_q) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      live_q <= expiry > ctrl.now;
    end
    if (wr) begin
      mac    <= ctrl.key;
      port   <= ctrl.wr_port;
      expiry <= ctrl.wr_expiry;
    end
  end

  assign resp_out.match = resp_in.match | match_q;
  assign resp_out.live  = resp_in.live | hit_here;
  assign resp_out.port  = resp_in.port | ({PORT_W{hit_here}} & port);
  assign free_out       = free_in | ~valid;

endmodule

// File: sv/mlb_table.sv
module mlb_table
  import mlb_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  output cell_resp_t resp
);

  cell_resp_t chain [0:ENTRIES];
  logic       free_chain [0:ENTRIES];
  cell_ctrl_t cell_ctrl;

  assign chain[0]      = '0;
  assign free_chain[0] = 1'b0;

  always_comb begin
    cell_ctrl           = ctrl;
    cell_ctrl.any_match = chain[ENTRIES].match;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mlb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .resp_in  (chain[i]),
      .free_in  (free_chain[i]),
      .resp_out (chain[i+1]),
      .free_out (free_chain[i+1])
    );
  end

  assign resp = chain[ENTRIES];

endmodule

// File: sv/mac_learning_bridge_forwarder.sv
// Learning bridge forwarding decision. Raise start with one frame event while
// busy is low; the decision comes back on deliver_local, forward_mask and
// table_hit during the single cycle that done is high, and must be taken then
// since the receiver cannot stall the block. Between the accepting edge and done
// come a compare and a write state when the source is learned, a compare and a
// read state when the destination is looked up, and a result state. busy is
// already low while done is high, so the next event can be taken at the edge
// that ends the done cycle. The address table is a row of TABLE_ENTRIES cells
// that compare in parallel; hit data and the free-entry claim ripple from cell
// to cell. No clearing pass is needed after reset. Registers sit at byte
// addresses 0, 8, 16 and 24; the user must write them only while the block is
// idle, which the block itself does not enforce.
module mac_learning_bridge_forwarder
  import mlb_pkg::*;
#(
  parameter int NUM_PORTS     = 8,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [1:0]        packet_kind,
  input  logic [MAC_W-1:0]  src_mac,
  input  logic [MAC_W-1:0]  dst_mac,
  input  logic [PORT_W-1:0] in_port,
  input  logic [TIME_W-1:0] now,
  output logic              done,
  output logic              deliver_local,
  output logic [MASK_W-1:0] forward_mask,
  output logic              table_hit
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LRN_CMP = 6'b000010,
    S_LRN_WR  = 6'b000100,
    S_LKP_CMP = 6'b001000,
    S_LKP_RD  = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

  localparam logic [ACT_W:0] PORT_CAP = (ACT_W+1)'(NUM_PORTS);

  state_t state, state_next;

  logic              enable_learning;
  logic [TIME_W-1:0] age_limit;
  logic [MAC_W-1:0]  own_mac;
  logic [ACT_W-1:0]  active_ports;

  logic              op_q;
  logic [PORT_W-1:0] inp_q;
  logic [MAC_W-1:0]  src_q;
  logic [MAC_W-1:0]  dst_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] exp_q;
  logic              deliver_q;
  logic [MASK_W-1:0] base_mask_q;
  logic              learn_q;
  logic              lookup_q;
  logic              hit_q;
  logic [PORT_W-1:0] hit_port_q;

  logic              accept;
  logic              cfg_wr;
  logic [ACT_W:0]    n_ports;
  logic [MASK_W-1:0] all_ports;
  logic [TIME_W:0]   exp_sum;
  logic [TIME_W-1:0] exp_sat;
  logic              own_dst;
  logic              learn_d;
  logic              lookup_d;
  logic              deliver_d;
  logic [MASK_W-1:0] base_mask_d;
  logic [MASK_W-1:0] flood_in;
  cell_ctrl_t        ctrl;
  cell_resp_t        resp;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign accept = start & ~busy;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_learning <= 1'b1;
      age_limit       <= AGE_RESET;
      own_mac         <= '0;
      active_ports    <= PORTS_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[CFG_AW-1:3]))
        REG_ENABLE:  enable_learning <= pwdata[0];
        REG_AGE:     age_limit       <= pwdata[TIME_W-1:0];
        REG_OWN_MAC: own_mac         <= pwdata[MAC_W-1:0];
        REG_PORTS:   active_ports    <= pwdata[ACT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[CFG_AW-1:3]))
      REG_ENABLE:  prdata = CFG_DW'(enable_learning);
      REG_AGE:     prdata = CFG_DW'(age_limit);
      REG_OWN_MAC: prdata = CFG_DW'(own_mac);
      REG_PORTS:   prdata = CFG_DW'(active_ports);
      default:     prdata = '0;
    endcase
  end

  // active ports, capped at the number of ports the bridge has
  assign n_ports = ({1'b0, active_ports} > PORT_CAP) ? PORT_CAP : {1'b0, active_ports};

  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      all_ports[j] = ((ACT_W+1)'(j) < n_ports);
    end
  end

  assign exp_sum  = {1'b0, now} + {1'b0, age_limit};
  assign exp_sat  = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
  assign own_dst  = (dst_mac == own_mac);
  assign flood_in = all_ports & ~port_bit(in_port);

  // classify the event at accept time
  always_comb begin
    learn_d     = 1'b0;
    lookup_d    = 1'b0;
    deliver_d   = 1'b0;
    base_mask_d = '0;
    if (operation) begin
      lookup_d    = enable_learning & ~dst_mac[40];
      base_mask_d = all_ports;
    end else if (packet_kind == KIND_BROADCAST || packet_kind == KIND_MULTICAST) begin
      learn_d     = enable_learning;
      deliver_d   = 1'b1;
      base_mask_d = flood_in;
    end else if (own_dst) begin
      learn_d   = enable_learning;
      deliver_d = 1'b1;
    end else if (packet_kind == KIND_OTHER) begin
      learn_d     = enable_learning;
      lookup_d    = enable_learning;
      base_mask_d = flood_in;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (learn_d) begin
            state_next = S_LRN_CMP;
          end else if (lookup_d) begin
            state_next = S_LKP_CMP;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_LRN_CMP: state_next = S_LRN_WR;
      S_LRN_WR:  state_next = lookup_q ? S_LKP_CMP : S_RESULT;
      S_LKP_CMP: state_next = S_LKP_RD;
      S_LKP_RD:  state_next = S_RESULT;
      S_RESULT:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_RESULT);
      if (accept) begin
        hit_q <= 1'b0;
      end else if (state == S_LKP_RD) begin
        hit_q <= resp.live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= operation;
      inp_q       <= in_port;
      src_q       <= src_mac;
      dst_q       <= dst_mac;
      now_q       <= now;
      exp_q       <= exp_sat;
      deliver_q   <= deliver_d;
      base_mask_q <= base_mask_d;
      learn_q     <= learn_d;
      lookup_q    <= lookup_d;
    end
    if (state == S_LKP_RD) begin
      hit_port_q <= resp.port;
    end
    if (state == S_RESULT) begin
      deliver_local <= deliver_q;
      table_hit     <= hit_q;
      if (hit_q && (op_q || hit_port_q != inp_q)) begin
        forward_mask <= port_bit(hit_port_q) & all_ports;
      end else begin
        forward_mask <= base_mask_q;
      end
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.cmp       = (state == S_LRN_CMP) || (state == S_LKP_CMP);
    ctrl.learn_wr  = (state == S_LRN_WR) && learn_q;
    ctrl.drop      = (state == S_LKP_RD);
    ctrl.key       = ((state == S_LKP_CMP) || (state == S_LKP_RD)) ? dst_q : src_q;
    ctrl.now       = now_q;
    ctrl.wr_port   = inp_q;
    ctrl.wr_expiry = exp_q;
  end

  mlb_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .resp (resp)
  );

endmodule

// File: sv/mlb_checker.sv
module mlb_checker
  import mlb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              deliver_local,
  input logic              table_hit,
  input logic [MASK_W-1:0] forward_mask
);

  // a word only comes out at the end of a busy stretch
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a preceding busy cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");

  a_busy_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result word");

  // a table hit never goes with local delivery
  a_hit_not_local: assert property (@(posedge clk) disable iff (rst)
    (done && table_hit) |-> !deliver_local)
    else $error("table hit on a locally delivered frame, mask %0h", forward_mask);

endmodule

bind mac_learning_bridge_forwarder mlb_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .deliver_local (deliver_local),
  .table_hit     (table_hit),
  .forward_mask  (forward_mask)
);

// File: test/tb_mac_learning_bridge_forwarder.sv
module tb_mac_learning_bridge_forwarder;
  timeunit 1ns;
  timeprecision 1ps;

  import mlb_pkg::*;

  localparam int NUM_PORTS     = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int POOL_SIZE     = 40;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 150;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [MAC_W-1:0] MAC_ALL_ONES = {MAC_W{1'b1}};

  typedef struct packed {
    logic              operation;
    pkt_kind_t         kind;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
  } frame_t;

  typedef struct packed {
    logic              deliver;
    logic [MASK_W-1:0] mask;
    logic              hit;
  } decision_t;

  class forward_board;
    bit                learn_en;
    bit [TIME_W-1:0]   age;
    bit [MAC_W-1:0]    own;
    bit [ACT_W-1:0]    nports;

    bit                ent_valid[TABLE_ENTRIES];
    bit [MAC_W-1:0]    ent_mac[TABLE_ENTRIES];
    bit [PORT_W-1:0]   ent_port[TABLE_ENTRIES];
    bit [TIME_W-1:0]   ent_expiry[TABLE_ENTRIES];

    decision_t         due_decisions[$];
    int                errors;
    int                frames;
    int                hits;
    int                locals;
    int                refused;

    function new();
      learn_en = 1'b1;
      age      = AGE_RESET;
      own      = '0;
      nports   = PORTS_RESET;
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_ENABLE:  learn_en = v[0];
        REG_AGE:     age = v[TIME_W-1:0];
        REG_OWN_MAC: own = v[MAC_W-1:0];
        REG_PORTS:   nports = v[ACT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [MASK_W-1:0] attached_ports();
      int n;
      n = (nports > NUM_PORTS) ? NUM_PORTS : int'(nports);
      return MASK_W'((9'(1) << n) - 9'(1));
    endfunction

    function void learn_source(bit [MAC_W-1:0] mac, bit [PORT_W-1:0] p, bit [TIME_W-1:0] t);
      bit [TIME_W:0] sum;
      bit [TIME_W-1:0] exp_t;
      int free_idx;
      if (!learn_en) return;
      sum = {1'b0, t} + {1'b0, age};
      exp_t = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      free_idx = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (ent_valid[i] && ent_mac[i] == mac) begin
          ent_port[i] = p;
          ent_expiry[i] = exp_t;
          return;
        end
        if (!ent_valid[i] && free_idx < 0) free_idx = i;
      end
      if (free_idx < 0) begin
        refused++;
        return;
      end
      ent_valid[free_idx]  = 1'b1;
      ent_mac[free_idx]    = mac;
      ent_port[free_idx]   = p;
      ent_expiry[free_idx] = exp_t;
    endfunction

    // a stale entry found on lookup is dropped from the table
    function bit find_live(bit [MAC_W-1:0] mac, bit [TIME_W-1:0] t, output bit [PORT_W-1:0] p);
      p = '0;
      if (!learn_en) return 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (ent_valid[i] && ent_mac[i] == mac) begin
          if (ent_expiry[i] > t) begin
            p = ent_port[i];
            return 1'b1;
          end
          ent_valid[i] = 1'b0;
          return 1'b0;
        end
      end
      return 1'b0;
    endfunction

    function decision_t predict_decision(frame_t f);
      decision_t d;
      bit [MASK_W-1:0] all;
      bit [MASK_W-1:0] ingress;
      bit [PORT_W-1:0] lp;
      d = '0;
      all = attached_ports();
      ingress = MASK_W'(1) << f.port;
      if (f.operation == OP_SEND) begin
        if (!f.dst[40] && find_live(f.dst, f.now, lp)) begin
          d.hit = 1'b1;
          d.mask = MASK_W'(1) << lp;
        end else begin
          d.mask = all;
        end
      end else if (f.kind == KIND_BROADCAST || f.kind == KIND_MULTICAST) begin
        d.deliver = 1'b1;
        learn_source(f.src, f.port, f.now);
        d.mask = all & ~ingress;
      end else if (f.dst == own) begin
        learn_source(f.src, f.port, f.now);
        d.deliver = 1'b1;
      end else if (f.kind == KIND_OTHER) begin
        learn_source(f.src, f.port, f.now);
        if (find_live(f.dst, f.now, lp)) begin
          d.hit = 1'b1;
          d.mask = (lp != f.port) ? (MASK_W'(1) << lp) : (all & ~ingress);
        end else begin
          d.mask = all & ~ingress;
        end
      end
      d.mask = d.mask & all;
      return d;
    endfunction

    function void note_frame(frame_t f);
      decision_t d;
      d = predict_decision(f);
      due_decisions = {due_decisions, d};
      frames++;
      if (d.hit) hits++;
      if (d.deliver) locals++;
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (due_decisions.size() == 0) begin
        $error("decision word with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = due_decisions.pop_front();
      if (got.deliver !== want.deliver) begin
        $error("deliver_local: expected %0b, got %0b", want.deliver, got.deliver);
        errors++;
      end
      if (got.mask !== want.mask) begin
        $error("forward_mask: expected %02h, got %02h", want.mask, got.mask);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("table_hit: expected %0b, got %0b", want.hit, got.hit);
        errors++;
      end
    endfunction

    function int pending();
      return due_decisions.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic              operation = 1'b0;
  logic [1:0]        packet_kind = '0;
  logic [MAC_W-1:0]  src_mac = '0;
  logic [MAC_W-1:0]  dst_mac = '0;
  logic [PORT_W-1:0] in_port = '0;
  logic [TIME_W-1:0] now = '0;
  logic              done;
  logic              deliver_local;
  logic [MASK_W-1:0] forward_mask;
  logic              table_hit;

  forward_board board;
  logic [MAC_W-1:0] mac_pool[POOL_SIZE];
  int settings_used;

  mac_learning_bridge_forwarder #(
    .NUM_PORTS    (NUM_PORTS),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .packet_kind  (packet_kind),
    .src_mac      (src_mac),
    .dst_mac      (dst_mac),
    .in_port      (in_port),
    .now          (now),
    .done         (done),
    .deliver_local(deliver_local),
    .forward_mask (forward_mask),
    .table_hit    (table_hit)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      board.check_decision(decision_t'{deliver_local, forward_mask, table_hit});
    end
  end

  // called at a rising edge; leaves start high when the next word follows at once
  task automatic send_frame(logic op, pkt_kind_t kind, logic [MAC_W-1:0] src,
                            logic [MAC_W-1:0] dst, logic [PORT_W-1:0] port,
                            logic [TIME_W-1:0] t, int gap);
    frame_t f;
    f = '{op, kind, src, dst, port, t};
    start       <= 1'b1;
    operation   <= op;
    packet_kind <= kind;
    src_mac     <= src;
    dst_mac     <= dst;
    in_port     <= port;
    now         <= t;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_frame(f);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // psel stays high between back-to-back writes; the caller closes the transfer
  task automatic write_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_reg(r, v);
  endtask

  task automatic program_regs(logic en, logic [TIME_W-1:0] age, logic [MAC_W-1:0] own,
                              logic [ACT_W-1:0] nports);
    write_reg(REG_ENABLE, CFG_DW'(en));
    write_reg(REG_AGE, CFG_DW'(age));
    write_reg(REG_OWN_MAC, CFG_DW'(own));
    write_reg(REG_PORTS, CFG_DW'(nports));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // drain outstanding decisions, then give the block a few cycles to go idle
  task automatic settle();
    start <= 1'b0;
    for (int w = 0; w < 400 && board.pending() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [MAC_W-1:0]  mac_a;
    logic [MAC_W-1:0]  mac_b;
    logic [MAC_W-1:0]  mac_c;
    logic [MAC_W-1:0]  own;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] t;
    logic [ACT_W-1:0]  nports;
    logic              en;
    logic              op;
    bit                no_idle;
    int                sel;
    int                gap;

    board = new();
    settings_used = 1;
    mac_a = 48'h02_11_22_33_44_55;
    mac_b = 48'h0a_bb_cc_dd_ee_01;
    mac_c = 48'h80_00_00_00_00_00;
    for (int i = 0; i < POOL_SIZE; i++) begin
      mac_pool[i] = MAC_W'({$urandom(), $urandom()});
      if (i % 4 != 0) mac_pool[i][40] = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: learning on, age 300, own address zero, all ports
    send_frame(OP_RECV, KIND_HOST,      mac_a, 48'h0, 3'd2, 32'd10, 0);
    send_frame(OP_RECV, KIND_HOST,      mac_b, mac_a, 3'd1, 32'd11, 1);
    send_frame(OP_RECV, KIND_BROADCAST, mac_b, MAC_ALL_ONES, 3'd7, 32'd12, 0);
    send_frame(OP_RECV, KIND_MULTICAST, 48'h0, 48'h01_00_5e_00_00_01, 3'd0, 32'd13, 2);
    send_frame(OP_RECV, KIND_OTHER,     MAC_ALL_ONES, mac_a, 3'd5, 32'd14, 0);
    // live entry that points back at the ingress port
    send_frame(OP_RECV, KIND_OTHER,     mac_b, mac_a, 3'd2, 32'd15, 0);
    send_frame(OP_RECV, KIND_OTHER,     mac_b, 48'h12_34_56_78_9a_bc, 3'd3, 32'd16, 3);
    send_frame(OP_RECV, KIND_OTHER,     mac_a, 48'h0, 3'd6, 32'd17, 0);
    send_frame(OP_SEND, KIND_HOST,      48'h0, mac_a, 3'd0, 32'd18, 0);
    send_frame(OP_SEND, KIND_BROADCAST, mac_b, mac_a | (48'h1 << 40), 3'd7, 32'd19, 1);
    send_frame(OP_SEND, KIND_OTHER,     mac_b, 48'h7e_00_00_00_00_01, 3'd4, 32'd20, 0);
    // mac_b is stale by now and gets dropped on lookup
    send_frame(OP_SEND, KIND_MULTICAST, mac_a, mac_b, 3'd1, 32'd1000, 0);
    send_frame(OP_RECV, KIND_OTHER,     mac_a, mac_b, 3'd1, 32'd1001, 2);
    // expiry saturates at the top of the time range
    send_frame(OP_RECV, KIND_OTHER,     mac_c, MAC_ALL_ONES, 3'd4, 32'hFFFF_FFF0, 0);
    send_frame(OP_SEND, KIND_HOST,      mac_a, mac_c, 3'd0, 32'hFFFF_FFFE, 0);
    send_frame(OP_SEND, KIND_HOST,      mac_a, mac_c, 3'd0, 32'hFFFF_FFFF, 1);
    // refresh moves an entry to a new port
    send_frame(OP_RECV, KIND_HOST,      mac_a, 48'h0, 3'd7, 32'd0, 0);
    send_frame(OP_SEND, KIND_OTHER,     mac_b, mac_a, 3'd3, 32'd0, 0);
    send_frame(OP_RECV, KIND_MULTICAST, mac_c, 48'h33_33_00_00_00_01, 3'd3, 32'd1, 4);
    send_frame(OP_RECV, KIND_OTHER,     mac_c, mac_a, 3'd7, 32'd2, 0);
    settle();

    tick = 32'd100;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin en = 1'b1; age = 32'd300;        own = MAC_W'({$urandom(), $urandom()});
                 nports = 4'd8; end
        1: begin en = 1'b1; age = 32'd1;          own = MAC_ALL_ONES; nports = 4'd1; end
        2: begin en = 1'b0; age = 32'd50;         own = 48'h0; nports = 4'd5; end
        3: begin en = 1'b1; age = 32'd40;         own = mac_pool[1]; nports = 4'd3; end
        4: begin en = 1'b1; age = 32'd300;        own = mac_pool[2]; nports = 4'd8;
                 tick = 32'hFFFF_FE00; end
        PHASES-1: begin en = 1'b1; age = 32'hFFFF_FFFF; own = mac_pool[3]; nports = 4'd8; end
        default: begin
          en = ($urandom_range(0, 3) != 0);
          age = $urandom_range(1, 500);
          own = MAC_W'({$urandom(), $urandom()});
          nports = ACT_W'($urandom_range(1, 8));
          tick = $urandom();
        end
      endcase
      program_regs(en, age, own, nports);
      no_idle = (ph % 3 == 1);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(0, 3) == 0) ? OP_SEND : OP_RECV;
        // the last phase brings in many fresh sources to fill the table
        if ((ph == PHASES-1 && $urandom_range(0, 1) == 0) || $urandom_range(0, 19) == 0)
          src = MAC_W'({$urandom(), $urandom()});
        else
          src = mac_pool[$urandom_range(0, POOL_SIZE-1)];
        sel = $urandom_range(0, 19);
        if (sel < 3)       dst = own;
        else if (sel < 5)  dst = MAC_ALL_ONES;
        else if (sel < 16) dst = mac_pool[$urandom_range(0, POOL_SIZE-1)];
        else               dst = MAC_W'({$urandom(), $urandom()});
        tick = tick + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                   : $urandom_range(0, 4));
        t = ($urandom_range(0, 29) == 0) ? TIME_W'($urandom()) : tick;
        if (no_idle)                        gap = 0;
        else if ($urandom_range(0, 9) < 5)  gap = 0;
        else if ($urandom_range(0, 9) < 8)  gap = $urandom_range(1, 3);
        else                                gap = $urandom_range(10, 40);
        send_frame(op, pkt_kind_t'($urandom_range(0, 3)), src, dst,
                   PORT_W'($urandom_range(0, 7)), t, gap);
      end
      settle();
    end

    if (board.pending() != 0) begin
      $error("%0d decision words never arrived", board.pending());
      board.errors++;
    end
    $display("covered %0d frame events under %0d register settings", board.frames,
             settings_used);
    $display("%0d table hits, %0d local deliveries, %0d sources refused by a full table",
             board.hits, board.locals, board.refused);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mlb_pkg.sv
sv/mlb_cell.sv
sv/mlb_table.sv
sv/mac_learning_bridge_forwarder.sv
sv/mlb_checker.sv
test/tb_mac_learning_bridge_forwarder.sv
